/* src/nsl_pkg.sv */
// Shared types, constants and codes for the nearest seed labeler.
`default_nettype none
package nsl_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SEEDS_DEF  = 256;
  localparam int COORD_BITS_DEF = 9;

  // Fixed field widths of the request and result items
  localparam int IDX_W    = 8;
  localparam int FCOORD_W = 9;
  localparam int LABEL_W  = 8;
  localparam int DIST_W   = 20;
  localparam int COUNT_W  = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SLICE  = 1'b1;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 opcode;
    logic [IDX_W-1:0]    seed_index;
    logic [FCOORD_W-1:0] row;
    logic [FCOORD_W-1:0] col;
    logic [FCOORD_W-1:0] slice;
    logic [LABEL_W-1:0]  seed_label;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] nearest_label;
    logic [DIST_W-1:0]  nearest_distance;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Marks one seed read as it travels down the distance pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } scan_tag_t;

  // Search result handed back to the controller
  typedef struct packed {
    logic               done;
    logic [LABEL_W-1:0] label;
    logic [DIST_W-1:0]  distance;
  } scan_res_t;

endpackage
`default_nettype wire

/* src/nsl_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module nsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/nsl_ctrl.sv */
// Scan sequencer: request handshake, seed read addresses and result register.
`default_nettype none
module nsl_ctrl #(
  parameter int MAX_SEEDS = nsl_pkg::MAX_SEEDS_DEF,
  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1,
  localparam int CW = $clog2(MAX_SEEDS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire nsl_pkg::op_t                 in_opcode,
  input  wire logic [nsl_pkg::COUNT_W-1:0]  seed_count,
  output logic                              start,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr,
  output nsl_pkg::scan_tag_t                tag,
  input  wire nsl_pkg::scan_res_t           res,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output nsl_pkg::out_item_t                out_data
);

  nsl_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic               empty_r, empty_nxt;
  nsl_pkg::scan_tag_t tag_r, tag_nxt;
  logic               out_valid_r;
  nsl_pkg::out_item_t out_data_r;
  logic               classify_acc;
  logic               last_rd;
  logic               load_out;
  logic [31:0]        cnt32;
  logic [31:0]        lim32;

  assign classify_acc = in_valid && !in_stall && (in_opcode == nsl_pkg::OP_CLASSIFY);
  assign last_rd      = (CW'(cnt_r + 1'b1) == n_r);

  // Clamp the seed count to the table depth
  always_comb begin
    cnt32 = 32'(seed_count);
    lim32 = (cnt32 > 32'(MAX_SEEDS)) ? 32'(MAX_SEEDS) : cnt32;
    n_nxt = lim32[CW-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nsl_pkg::ST_IDLE: begin
        if (classify_acc) begin
          state_nxt = (n_nxt == '0) ? nsl_pkg::ST_FINISH : nsl_pkg::ST_SCAN;
        end
      end
      nsl_pkg::ST_SCAN: begin
        if (last_rd) begin
          state_nxt = nsl_pkg::ST_DRAIN;
        end
      end
      nsl_pkg::ST_DRAIN: begin
        if (res.done) begin
          state_nxt = nsl_pkg::ST_FINISH;
        end
      end
      nsl_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = nsl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nsl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    load_out  = 1'b0;
    start     = 1'b0;
    cnt_nxt   = cnt_r;
    empty_nxt = empty_r;
    tag_nxt   = '0;
    case (state_r)
      nsl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        start    = classify_acc;
        cnt_nxt  = '0;
        if (classify_acc) begin
          empty_nxt = (n_nxt == '0);
        end
      end
      nsl_pkg::ST_SCAN: begin
        ram_re        = 1'b1;
        cnt_nxt       = CW'(cnt_r + 1'b1);
        tag_nxt.vld   = 1'b1;
        tag_nxt.first = (cnt_r == '0);
        tag_nxt.last  = last_rd;
      end
      nsl_pkg::ST_DRAIN: begin
      end
      nsl_pkg::ST_FINISH: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  assign ram_raddr = cnt_r[AW-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsl_pkg::ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      empty_r     <= 1'b0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      empty_r <= empty_nxt;
      tag_r   <= tag_nxt;
      if (classify_acc) begin
        n_r <= n_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register; an empty table gives label zero and the largest distance
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (empty_r) begin
        out_data_r.nearest_label    <= '0;
        out_data_r.nearest_distance <= nsl_pkg::DIST_MAX;
      end else begin
        out_data_r.nearest_label    <= res.label;
        out_data_r.nearest_distance <= res.distance;
      end
    end
  end

  assign tag       = tag_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* src/nsl_dist.sv */
// Distance pipeline: differences, squares, sum, and running nearest-seed pick.
`default_nettype none
module nsl_dist #(
  parameter int COORD_BITS = nsl_pkg::COORD_BITS_DEF,
  localparam int CB = COORD_BITS,
  localparam int WW = 3 * COORD_BITS + nsl_pkg::LABEL_W,
  localparam int SW = 2 * COORD_BITS + 2,
  localparam int EW = (SW > nsl_pkg::DIST_W) ? SW : nsl_pkg::DIST_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [CB-1:0]            q_row,
  input  wire logic [CB-1:0]            q_col,
  input  wire logic [CB-1:0]            q_slice,
  input  wire logic                     use_slice,
  input  wire nsl_pkg::scan_tag_t       tag,
  input  wire logic [WW-1:0]            rdata,
  output nsl_pkg::scan_res_t            res
);

  logic [CB-1:0]                 qr_r, qc_r, qs_r;
  logic [CB-1:0]                 sr, sc, ss;
  logic [nsl_pkg::LABEL_W-1:0]   sl;
  nsl_pkg::scan_tag_t            t1_r, t2_r, t3_r;
  logic [CB-1:0]                 dr_r, dc_r, ds_r;
  logic [CB-1:0]                 dr_nxt, dc_nxt, ds_nxt;
  logic [2*CB-1:0]               qdr_r, qdc_r, qds_r;
  logic [SW-1:0]                 sum_r;
  logic [nsl_pkg::LABEL_W-1:0]   l1_r, l2_r, l3_r;
  logic [SW-1:0]                 best_r;
  logic [nsl_pkg::LABEL_W-1:0]   best_lbl_r;
  logic                          done_r;
  logic                          take;
  logic [EW-1:0]                 best_ext;

  // Unpack a table entry
  assign sr = rdata[CB-1:0];
  assign sc = rdata[2*CB-1:CB];
  assign ss = rdata[3*CB-1:2*CB];
  assign sl = rdata[WW-1:3*CB];

  // Hold the query point for the whole scan
  always_ff @(posedge clk) begin
    if (start) begin
      qr_r <= q_row;
      qc_r <= q_col;
      qs_r <= q_slice;
    end
  end

  // Absolute differences; drop the slice term in 2D mode
  always_comb begin
    dr_nxt = (qr_r >= sr) ? CB'(qr_r - sr) : CB'(sr - qr_r);
    dc_nxt = (qc_r >= sc) ? CB'(qc_r - sc) : CB'(sc - qc_r);
    ds_nxt = '0;
    if (use_slice) begin
      ds_nxt = (qs_r >= ss) ? CB'(qs_r - ss) : CB'(ss - qs_r);
    end
  end

  // Tag valid bits down the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r   <= '0;
      t2_r   <= '0;
      t3_r   <= '0;
      done_r <= 1'b0;
    end else begin
      t1_r   <= tag;
      t2_r   <= t1_r;
      t3_r   <= t2_r;
      done_r <= t3_r.vld && t3_r.last;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    dr_r  <= dr_nxt;
    dc_r  <= dc_nxt;
    ds_r  <= ds_nxt;
    l1_r  <= sl;
    qdr_r <= {{CB{1'b0}}, dr_r} * {{CB{1'b0}}, dr_r};
    qdc_r <= {{CB{1'b0}}, dc_r} * {{CB{1'b0}}, dc_r};
    qds_r <= {{CB{1'b0}}, ds_r} * {{CB{1'b0}}, ds_r};
    l2_r  <= l1_r;
    sum_r <= SW'(qdr_r) + SW'(qdc_r) + SW'(qds_r);
    l3_r  <= l2_r;
  end

  // Keep strictly smaller distances so the lowest entry wins a tie
  assign take = t3_r.vld && (t3_r.first || (sum_r < best_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= sum_r;
      best_lbl_r <= l3_r;
    end
  end

  // Saturate the reported distance
  assign best_ext     = EW'(best_r);
  assign res.done     = done_r;
  assign res.label    = best_lbl_r;
  assign res.distance = (best_ext > EW'(nsl_pkg::DIST_MAX)) ? nsl_pkg::DIST_MAX
                                                             : best_ext[nsl_pkg::DIST_W-1:0];

endmodule
`default_nettype wire

/* src/nearest_seed_labeler_unit.sv */
// Top level of the nearest seed labeler: seed table, scan sequencer and distance pipeline.
//
// A load request writes one seed into the table and is taken back to back. A classify
// request reads the table one entry per cycle through the single read port of the seed
// memory, so it occupies the block until its result reaches the output register; the
// input stalls for that time, and longer while an earlier result still sits stalled in
// the output register. A finished result waits in the output register while a
// following load is taken. Ties go to the lowest table entry, and distances above
// 1048575 report as 1048575. Table entries hold nothing defined until loaded.
`default_nettype none
module nearest_seed_labeler_unit #(
  parameter int MAX_SEEDS  = nsl_pkg::MAX_SEEDS_DEF,
  parameter int COORD_BITS = nsl_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire nsl_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output nsl_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [nsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CB = COORD_BITS;
  localparam int WW = 3 * COORD_BITS + nsl_pkg::LABEL_W;
  localparam int FW = nsl_pkg::FCOORD_W;

  logic [nsl_pkg::COUNT_W-1:0] seed_count_r;
  logic                        use_slice_r;
  logic                        start;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [AW-1:0]               ram_waddr;
  logic [WW-1:0]               ram_wdata;
  logic [WW-1:0]               ram_rdata;
  nsl_pkg::scan_tag_t          tag;
  nsl_pkg::scan_res_t          res;
  logic [AW+nsl_pkg::IDX_W-1:0] idx_ext;
  logic [CB+FW-1:0]            row_ext, col_ext, slice_ext;
  logic [CB-1:0]               c_row, c_col, c_slice;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r <= '0;
      use_slice_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsl_pkg::REG_SEED_COUNT: seed_count_r <= cfg_data[nsl_pkg::COUNT_W-1:0];
        nsl_pkg::REG_USE_SLICE:  use_slice_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Keep the low coordinate bits and the table address
  assign row_ext   = {{CB{1'b0}}, in_data.row};
  assign col_ext   = {{CB{1'b0}}, in_data.col};
  assign slice_ext = {{CB{1'b0}}, in_data.slice};
  assign c_row     = row_ext[CB-1:0];
  assign c_col     = col_ext[CB-1:0];
  assign c_slice   = slice_ext[CB-1:0];
  assign idx_ext   = {{AW{1'b0}}, in_data.seed_index};
  assign ram_waddr = idx_ext[AW-1:0];

  // Write a seed on a load request inside the table
  assign ram_we    = in_valid && !in_stall && (in_data.opcode == nsl_pkg::OP_LOAD) &&
                     (32'(in_data.seed_index) < 32'(MAX_SEEDS));
  assign ram_wdata = {in_data.seed_label, c_slice, c_col, c_row};

  nsl_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_SEEDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nsl_ctrl #(
    .MAX_SEEDS (MAX_SEEDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_data.opcode),
    .seed_count (seed_count_r),
    .start      (start),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .tag        (tag),
    .res        (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  nsl_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .q_row     (c_row),
    .q_col     (c_col),
    .q_slice   (c_slice),
    .use_slice (use_slice_r),
    .tag       (tag),
    .rdata     (ram_rdata),
    .res       (res)
  );

endmodule
`default_nettype wire

/* src/nsl_checker.sv */
// Port-level assertions for the nearest seed labeler, bound to the top level.
`default_nettype none
module nsl_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire nsl_pkg::in_item_t               in_data,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire nsl_pkg::out_item_t              out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A classify request blocks the input for at least the next cycle
  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == nsl_pkg::OP_CLASSIFY) |=> in_stall)
    else $error("input taken right after a classify request");

  // A load request leaves the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == nsl_pkg::OP_LOAD) |=> !in_stall)
    else $error("load request blocked the input");

  // A new result appears only at the end of a classify search
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a classify in progress");

endmodule

bind nearest_seed_labeler_unit nsl_checker u_nsl_checker (.*);
`default_nettype wire

/* tb/sv/tb_nearest_seed_labeler_unit.sv */
// Testbench for the nearest seed labeler: directed and random requests against a local model.
`default_nettype none
module tb_nearest_seed_labeler_unit;

  localparam int TABLE_DEPTH   = nsl_pkg::MAX_SEEDS_DEF;
  localparam int IDX_W         = nsl_pkg::IDX_W;
  localparam int CRD_W         = nsl_pkg::FCOORD_W;
  localparam int LBL_W         = nsl_pkg::LABEL_W;
  localparam int DST_W         = nsl_pkg::DIST_W;
  localparam int CNT_W         = nsl_pkg::COUNT_W;
  localparam int CIDX_W        = nsl_pkg::CFG_IDX_W;
  localparam int CDAT_W        = nsl_pkg::CFG_DATA_W;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = TABLE_DEPTH + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int TARGET_REQS   = 800;
  localparam int CYCLE_LIMIT   = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  nsl_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nsl_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDAT_W-1:0] cfg_data = '0;

  // Local copy of the seed table and register state
  logic [CRD_W-1:0] seed_row [TABLE_DEPTH];
  logic [CRD_W-1:0] seed_col [TABLE_DEPTH];
  logic [CRD_W-1:0] seed_slc [TABLE_DEPTH];
  logic [LBL_W-1:0] seed_lbl [TABLE_DEPTH];
  logic [CNT_W-1:0] scan_count = '0;
  logic slice_on = 1'b0;

  // Nearest-seed answers still owed by the block, oldest first
  nsl_pkg::out_item_t nearest_q [$];

  int errors = 0;
  int cycles = 0;
  int n_loads = 0;
  int n_classify = 0;
  int n_results = 0;
  int n_cfg = 0;
  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;
  logic press_req = 1'b0;
  logic press_hold = 1'b0;
  int stall_left = 0;

  nearest_seed_labeler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sq_gap(logic [CRD_W-1:0] a, logic [CRD_W-1:0] b);
    int unsigned g;
    g = (a >= b) ? 32'(a) - 32'(b) : 32'(b) - 32'(a);
    return g * g;
  endfunction

  // Brute-force search over the scanned part of the table; first seed wins a tie
  function automatic nsl_pkg::out_item_t nearest_seed(nsl_pkg::in_item_t q);
    int unsigned n, d, best;
    logic found;
    nsl_pkg::out_item_t res;
    n = (32'(scan_count) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(scan_count);
    found = 1'b0;
    best = 0;
    res.nearest_label = '0;
    res.nearest_distance = nsl_pkg::DIST_MAX;
    for (int i = 0; i < n; i++) begin
      d = sq_gap(q.row, seed_row[i]) + sq_gap(q.col, seed_col[i]);
      if (slice_on) d += sq_gap(q.slice, seed_slc[i]);
      if (!found || d < best) begin
        found = 1'b1;
        best = d;
        res.nearest_label = seed_lbl[i];
      end
    end
    if (found) begin
      res.nearest_distance = (best > nsl_pkg::DIST_MAX) ? nsl_pkg::DIST_MAX : best[DST_W-1:0];
    end
    return res;
  endfunction

  // Update the local table or queue the expected answer for one accepted request
  function automatic void take_request(nsl_pkg::in_item_t q);
    if (q.opcode == nsl_pkg::OP_LOAD) begin
      seed_row[q.seed_index] = q.row;
      seed_col[q.seed_index] = q.col;
      seed_slc[q.seed_index] = q.slice;
      seed_lbl[q.seed_index] = q.seed_label;
      n_loads++;
    end else begin
      nearest_q.push_back(nearest_seed(q));
      n_classify++;
    end
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  function automatic nsl_pkg::in_item_t load_req(int idx, int r, int c, int s, int lbl);
    nsl_pkg::in_item_t q;
    q.opcode = nsl_pkg::OP_LOAD;
    q.seed_index = IDX_W'(idx);
    q.row = CRD_W'(r);
    q.col = CRD_W'(c);
    q.slice = CRD_W'(s);
    q.seed_label = LBL_W'(lbl);
    return q;
  endfunction

  // Unused fields of a classify request carry random junk
  function automatic nsl_pkg::in_item_t classify_req(int r, int c, int s);
    nsl_pkg::in_item_t q;
    q.opcode = nsl_pkg::OP_CLASSIFY;
    q.seed_index = IDX_W'($urandom_range(0, 255));
    q.row = CRD_W'(r);
    q.col = CRD_W'(c);
    q.slice = CRD_W'(s);
    q.seed_label = LBL_W'($urandom_range(0, 255));
    return q;
  endfunction

  // Offer one request, hold it until taken
  task automatic send_req(nsl_pkg::in_item_t q);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
    take_request(q);
  endtask

  // Drop the request line and wait until the block has nothing in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nsl_pkg::REG_SEED_COUNT: scan_count = val;
      nsl_pkg::REG_USE_SLICE: slice_on = val[0];
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (press_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Count out a long receiver hold-off
  initial begin : hold_off
    forever begin
      @(posedge press_req);
      @(posedge clk);
      press_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      press_hold <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    nsl_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (nearest_q.size() == 0) begin
        $error("unexpected result: label %0d distance %0d",
               out_data.nearest_label, out_data.nearest_distance);
        errors++;
      end else begin
        want = nearest_q.pop_front();
        if (out_data.nearest_label !== want.nearest_label) begin
          $error("nearest_label: expected %0d, got %0d",
                 want.nearest_label, out_data.nearest_label);
          errors++;
        end
        if (out_data.nearest_distance !== want.nearest_distance) begin
          $error("nearest_distance: expected %0d, got %0d",
                 want.nearest_distance, out_data.nearest_distance);
          errors++;
        end
        n_results++;
      end
    end
  end

  // Empty table: label 0 and saturated distance
  task automatic test_empty_table();
    send_req(classify_req(0, 0, 0));
    send_req(classify_req(511, 511, 511));
    settle();
    write_reg(nsl_pkg::REG_SEED_COUNT, 9'd0);
    write_reg(nsl_pkg::REG_USE_SLICE, 9'd1);
    send_req(classify_req(511, 0, 511));
    settle();
  endtask

  // Extremes, ties and the slice term on a handful of seeds
  task automatic test_directed_search();
    send_req(load_req(0, 0, 0, 511, 8'h5A));
    send_req(load_req(1, 0, 0, 0, 8'hA5));
    send_req(load_req(2, 511, 511, 511, 8'hFF));
    send_req(load_req(3, 511, 0, 0, 8'h00));
    send_req(load_req(255, 511, 511, 511, 8'hFF));
    settle();
    write_reg(nsl_pkg::REG_SEED_COUNT, 9'd4);
    write_reg(nsl_pkg::REG_USE_SLICE, 9'd0);
    // seeds 0 and 1 differ only in slice, so in 2D seed 0 wins the tie
    send_req(classify_req(0, 0, 0));
    send_req(classify_req(511, 511, 0));
    send_req(classify_req(256, 0, 0));
    send_req(classify_req(255, 0, 511));
    send_req(classify_req(0, 511, 511));
    settle();
    write_reg(nsl_pkg::REG_USE_SLICE, 9'd1);
    send_req(classify_req(0, 0, 0));
    send_req(classify_req(0, 0, 511));
    send_req(classify_req(511, 511, 511));
    send_req(classify_req(0, 511, 256));
    send_req(classify_req(511, 0, 511));
    settle();
  endtask

  // Whole table loaded, then counts at and beyond the table size
  task automatic test_full_table();
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_req(load_req(i, rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 255)));
    settle();
    write_reg(nsl_pkg::REG_SEED_COUNT, 9'd256);
    send_req(classify_req(rand_coord(), rand_coord(), rand_coord()));
    send_req(classify_req(0, 0, 0));
    settle();
    write_reg(nsl_pkg::REG_SEED_COUNT, 9'd511);
    write_reg(nsl_pkg::REG_USE_SLICE, 9'd0);
    send_req(classify_req(511, 511, 511));
    send_req(classify_req(rand_coord(), rand_coord(), rand_coord()));
    settle();
    write_reg(nsl_pkg::REG_SEED_COUNT, 9'd257);
    send_req(classify_req(rand_coord(), rand_coord(), rand_coord()));
    settle();
  endtask

  // Receiver holds off while back-to-back requests fill the block
  task automatic test_input_backpressure();
    write_reg(nsl_pkg::REG_SEED_COUNT, 9'd8);
    tx_idle_on = 1'b0;
    press_req <= 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 1)
        send_req(load_req($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 255)));
      else
        send_req(classify_req(rand_coord(), rand_coord(), rand_coord()));
    end
    settle();
  endtask

  // Random settings, each followed by a burst of loads and queries
  task automatic test_random_phases();
    int n, k, len;
    nsl_pkg::in_item_t q;
    while (n_loads + n_classify < TARGET_REQS) begin
      case ($urandom_range(0, 19))
        0: n = 0;
        1: n = 256;
        2: n = $urandom_range(257, 511);
        default: n = $urandom_range(1, 24);
      endcase
      write_reg(nsl_pkg::REG_SEED_COUNT, CDAT_W'(n));
      write_reg(nsl_pkg::REG_USE_SLICE, {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      len = $urandom_range(30, 60);
      for (int j = 0; j < len; j++) begin
        k = (n > 0) ? $urandom_range(0, n - 1) : 0;
        case ($urandom_range(0, 9))
          0, 1: q = load_req((n > 0 && $urandom_range(0, 1)) ? k : $urandom_range(0, 255),
                             rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 255));
          // query on or next to a scanned seed
          2, 3, 4: q = classify_req(seed_row[k] + $urandom_range(0, 2) - 1,
                                    seed_col[k] + $urandom_range(0, 2) - 1,
                                    seed_slc[k] + $urandom_range(0, 2) - 1);
          default: q = classify_req(rand_coord(), rand_coord(), rand_coord());
        endcase
        send_req(q);
      end
      settle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_directed_search();
    test_full_table();
    test_input_backpressure();
    test_random_phases();
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (nearest_q.size() != 0) begin
      $error("%0d expected results never arrived", nearest_q.size());
    end
    $display("Sent %0d seed loads and %0d point queries; checked %0d results.",
             n_loads, n_classify, n_results);
    $display("Applied %0d register writes across 2D/3D modes and seed counts 0 to 511.", n_cfg);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
